@@ rtl/core/lprt_pkg.sv @@
// Shared types and codes of the longest-prefix route table.
package lprt_pkg;

    // Request codes carried in the input tuser
    typedef enum logic [1:0] {
        REQ_INSERT = 2'd0,
        REQ_DELETE = 2'd1,
        REQ_LOOKUP = 2'd2
    } t_req_kind;

    // Result codes carried in the output tuser
    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_MISS = 2'd1,
        ST_FULL = 2'd2
    } t_status;

    // One stored route
    typedef struct packed {
        logic [31:0] net;
        logic [31:0] mask;
        logic [31:0] hop;
        logic [3:0]  port;
    } t_entry;

    // Request held for the whole pass and broadcast to every cell
    typedef struct packed {
        t_req_kind   kind;
        logic        full;
        logic [31:0] addr;
        logic [31:0] mask;
        logic [31:0] hop;
        logic [3:0]  port;
    } t_req;

    // Word handed from cell to cell: flag means placed (insert),
    // hole open (delete) or hit (lookup); entry is the carried route
    typedef struct packed {
        logic   flag;
        t_entry entry;
    } t_token;

endpackage

@@ rtl/core/lprt_cell.sv @@
// One route slot of the table chain with its token stage.
module lprt_cell #(
    parameter int IDX = 0,
    parameter int CW  = 6
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  lprt_pkg::t_req    i_req,
    input  logic [CW-1:0]     i_count,
    input  logic              i_tok_v,
    input  lprt_pkg::t_token  i_tok,
    input  logic              i_pull,
    input  lprt_pkg::t_entry  i_next,
    output logic              o_tok_v,
    output lprt_pkg::t_token  o_tok,
    output lprt_pkg::t_entry  o_entry
);
    import lprt_pkg::*;

    localparam logic [CW-1:0] MY_IDX = CW'(IDX);

    t_entry r_entry;
    t_entry n_entry;
    t_token r_tok;
    t_token n_tok;
    logic   r_tok_v;
    logic   here;
    t_entry new_entry;

    assign here = MY_IDX < i_count;
    assign new_entry = '{net: i_req.addr, mask: i_req.mask, hop: i_req.hop, port: i_req.port};

    // Work the passing word against the stored route
    always_comb begin
        n_entry = r_entry;
        n_tok   = i_tok;
        if (i_tok_v) begin
            case (i_req.kind)
                REQ_INSERT: begin
                    if (!i_req.full) begin
                        if (!i_tok.flag && (MY_IDX == i_count ||
                                (here && r_entry.mask <= i_req.mask))) begin
                            n_entry       = new_entry;
                            n_tok.flag    = 1'b1;
                            n_tok.entry   = r_entry;
                        end else if (i_tok.flag && MY_IDX <= i_count) begin
                            n_entry       = i_tok.entry;
                            n_tok.entry   = r_entry;
                        end
                    end
                end
                REQ_DELETE: begin
                    if (here && !i_tok.flag && r_entry.net == i_req.addr &&
                            r_entry.mask == i_req.mask) begin
                        n_tok.flag = 1'b1;
                    end
                end
                REQ_LOOKUP: begin
                    if (here && !i_tok.flag &&
                            (r_entry.mask & i_req.addr) == r_entry.net) begin
                        n_tok.flag  = 1'b1;
                        n_tok.entry = r_entry;
                    end
                end
                default: ;
            endcase
        end
        // Close the hole left by a delete: take the neighbor's route
        if (i_pull) begin
            n_entry = i_next;
        end
    end

    // Hold the route, advance the word
    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
        r_tok   <= n_tok;
        if (!i_rst_n) begin
            r_tok_v <= 1'b0;
        end else begin
            r_tok_v <= i_tok_v;
        end
    end

    assign o_tok_v = r_tok_v;
    assign o_tok   = r_tok;
    assign o_entry = r_entry;

endmodule

@@ rtl/core/longest_prefix_route_table_unit.sv @@
// Top level of the longest-prefix route table: cell chain, result stage, count.
//
// Input stream: tuser carries the request code (insert, delete, lookup),
// tdata the address, mask, next hop and interface. Output stream: tuser
// carries the status (ok or hit, miss or not found, table full), tdata the
// egress interface and next hop of a lookup hit, zero otherwise.
// Routes live in a row of TABLE_DEPTH cells, longest mask first. A request
// runs as a word through the whole row, one cell per cycle; an insert
// shifts later routes down as it passes, a delete pulls them back up.
// The request is registered, its word passes the register of every cell,
// and the result is then registered; the next request is taken only once
// its predecessor's result is registered, so requests are served one at a
// time, and the length of the cell row sets how long each one takes.
// Reset empties the table (route count to zero) and clears all valid flags.
// A stalled receiver holds the result in the output register; one more
// result can wait in a skid register, and no request is taken while it is
// occupied.
module longest_prefix_route_table_unit #(
    parameter int TABLE_DEPTH = 32
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_tvalid,
    output logic         o_s_tready,
    input  logic [103:0] i_s_tdata,   // address[31:0], net_mask, new_next_hop, new_intf, pad
    input  logic [1:0]   i_s_tuser,   // req_type
    output logic         o_m_tvalid,
    input  logic         i_m_tready,
    output logic [39:0]  o_m_tdata,   // eg_port[3:0], found_next_hop, pad
    output logic [1:0]   o_m_tuser    // status
);
    import lprt_pkg::*;

    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam logic [CW-1:0] DEPTH_CNT = CW'(TABLE_DEPTH);

    t_req           r_req;
    logic           r_start;
    logic           r_busy;
    logic [CW-1:0]  r_count;
    logic           r_out_v;
    t_status        r_out_st;
    logic [3:0]     r_out_port;
    logic [31:0]    r_out_hop;
    logic           r_skid_v;
    t_status        r_skid_st;
    logic [3:0]     r_skid_port;
    logic [31:0]    r_skid_hop;

    logic           s_acc;
    logic           m_pop;
    logic           fin;
    t_status        fin_st;
    logic [3:0]     fin_port;
    logic [31:0]    fin_hop;
    t_token         head_tok;

    logic   [TABLE_DEPTH-1:0] tok_v;
    t_token                   tok   [TABLE_DEPTH];
    t_entry                   entry [TABLE_DEPTH];
    logic   [TABLE_DEPTH-1:0] pull;

    assign o_s_tready = !r_busy && !r_skid_v;
    assign s_acc      = i_s_tvalid && o_s_tready;
    assign m_pop      = r_out_v && i_m_tready;
    assign head_tok   = '0;

    // Latch the request and launch its word
    always_ff @(posedge i_clk) begin
        if (s_acc) begin
            r_req.kind <= t_req_kind'(i_s_tuser);
            r_req.full <= (r_count == DEPTH_CNT);
            r_req.addr <= i_s_tdata[31:0];
            r_req.mask <= i_s_tdata[63:32];
            r_req.hop  <= i_s_tdata[95:64];
            r_req.port <= i_s_tdata[99:96];
        end
        if (!i_rst_n) begin
            r_start <= 1'b0;
        end else begin
            r_start <= s_acc;
        end
    end

    // Row of route cells
    for (genvar k = 0; k < TABLE_DEPTH; k++) begin : g_cell
        if (k == TABLE_DEPTH - 1) begin : g_last
            assign pull[k] = 1'b0;
            lprt_cell #(.IDX(k), .CW(CW)) u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_req   (r_req),
                .i_count (r_count),
                .i_tok_v ((k == 0) ? r_start : tok_v[(k == 0) ? 0 : k - 1]),
                .i_tok   ((k == 0) ? head_tok : tok[(k == 0) ? 0 : k - 1]),
                .i_pull  (pull[k]),
                .i_next  ('0),
                .o_tok_v (tok_v[k]),
                .o_tok   (tok[k]),
                .o_entry (entry[k])
            );
        end else begin : g_mid
            // Pull from the right-hand cell while a delete's hole passes it
            assign pull[k] = tok_v[k] && r_req.kind == REQ_DELETE && tok[k].flag &&
                             (CW'(k + 1) < r_count);
            lprt_cell #(.IDX(k), .CW(CW)) u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_req   (r_req),
                .i_count (r_count),
                .i_tok_v ((k == 0) ? r_start : tok_v[(k == 0) ? 0 : k - 1]),
                .i_tok   ((k == 0) ? head_tok : tok[(k == 0) ? 0 : k - 1]),
                .i_pull  (pull[k]),
                .i_next  (entry[k + 1]),
                .o_tok_v (tok_v[k]),
                .o_tok   (tok[k]),
                .o_entry (entry[k])
            );
        end
    end

    // Form the result when the word leaves the row
    assign fin = tok_v[TABLE_DEPTH-1];
    always_comb begin
        fin_st   = ST_MISS;
        fin_port = '0;
        fin_hop  = '0;
        case (r_req.kind)
            REQ_INSERT: fin_st = r_req.full ? ST_FULL : ST_OK;
            REQ_DELETE: fin_st = tok[TABLE_DEPTH-1].flag ? ST_OK : ST_MISS;
            REQ_LOOKUP: begin
                if (tok[TABLE_DEPTH-1].flag) begin
                    fin_st   = ST_OK;
                    fin_port = tok[TABLE_DEPTH-1].entry.port;
                    fin_hop  = tok[TABLE_DEPTH-1].entry.hop;
                end
            end
            default: fin_st = ST_MISS;
        endcase
    end

    // Count routes, track busy, hold results in output and skid registers
    always_ff @(posedge i_clk) begin
        if (fin && (!r_out_v || m_pop)) begin
            r_out_st   <= fin_st;
            r_out_port <= fin_port;
            r_out_hop  <= fin_hop;
        end else if (m_pop && r_skid_v) begin
            r_out_st   <= r_skid_st;
            r_out_port <= r_skid_port;
            r_out_hop  <= r_skid_hop;
        end
        if (fin && r_out_v && !m_pop) begin
            r_skid_st   <= fin_st;
            r_skid_port <= fin_port;
            r_skid_hop  <= fin_hop;
        end
        if (!i_rst_n) begin
            r_busy   <= 1'b0;
            r_count  <= '0;
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else begin
            if (s_acc) begin
                r_busy <= 1'b1;
            end else if (fin) begin
                r_busy <= 1'b0;
            end
            if (fin && r_req.kind == REQ_INSERT && !r_req.full) begin
                r_count <= r_count + CW'(1);
            end else if (fin && r_req.kind == REQ_DELETE && tok[TABLE_DEPTH-1].flag) begin
                r_count <= r_count - CW'(1);
            end
            if (fin) begin
                r_out_v  <= 1'b1;
                r_skid_v <= r_out_v && !m_pop;
            end else if (m_pop) begin
                r_out_v  <= r_skid_v;
                r_skid_v <= 1'b0;
            end
        end
    end

    assign o_m_tvalid = r_out_v;
    assign o_m_tuser  = r_out_st;
    assign o_m_tdata  = {4'b0000, r_out_hop, r_out_port};

    // Route count stays within the row
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= DEPTH_CNT)
        else $error("route count beyond table depth");

    // At most one request word travels the row
    a_one_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({tok_v, r_start}))
        else $error("more than one request in the cell row");

    // Accepted request keeps the block busy until its word leaves the row
    a_busy_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy && !fin |=> r_busy)
        else $error("busy dropped before result");

    // Count changes only when a word leaves the row
    a_count_update: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !fin |=> $stable(r_count))
        else $error("route count moved without a finished request");

endmodule
